@@ sv/amd_pkg.sv @@
// shared types and constants of the accelerometer median motion detector
// no dependencies
package amd_pkg;
   localparam int AXES = 3;
   localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
   localparam logic [31:0] RECIP_125 = 32'd2199023256;
   localparam logic [12:0] SCORE_JUMP = 13'd4950;
   localparam logic [12:0] SCORE_MAX = 13'd5000;
   localparam logic [12:0] SCORE_ON = 13'd4995;
   localparam logic [12:0] SCORE_OFF = 13'd3;
   localparam logic [35:0] LEVEL_STEP = 36'd4000000;
   localparam int LEVEL_MAX = 15;

   localparam logic [1:0] CSR_ACT_THRESH = 2'd0;
   localparam logic [1:0] CSR_MOT_THRESH = 2'd1;
   localparam logic [1:0] CSR_ACT_HOLD = 2'd2;
   localparam logic [1:0] CSR_WARMUP = 2'd3;

   typedef logic signed [15:0] sample_type;
   typedef sample_type [AXES-1:0] sample_vec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      B_IDLE, B_DIFF, B_MUL1, B_FAST, B_MUL2, B_SLOW, B_SQUARE, B_DONE
   } back_state_type;
endpackage

@@ sv/accel_median_motion_detector_unit.sv @@
// top level of the accelerometer median motion detector
// depends on amd_pkg, amd_front, amd_fifo, amd_back
// Each sample is median-filtered per axis on entry and queued in a two-entry
// queue; the back end then runs each item through a sequencer (two reciprocal
// multiplies for the averages and a squaring step) and pops the next item only
// after the last result is in the output register. Results wait there while
// the front end keeps taking samples until the queue is full.
module accel_median_motion_detector_unit #(
   parameter int MEDIAN_TAPS = 5
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic signed [15:0] req_sample_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_active,
   output logic rsp_moving,
   output logic [3:0] rsp_drive_quality,
   output logic [3:0] rsp_energy_level,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   import amd_pkg::*;
   sample_vec_type in_sample, filtered, q_data;
   fifo_status_type q_status;
   logic push, q_pop;

   assign in_sample = {req_sample_z, req_sample_y, req_sample_x};
   assign req_stall = q_status.full;

   amd_front #(.MEDIAN_TAPS(MEDIAN_TAPS)) u_front (
      .clock, .reset, .push_ok(!q_status.full), .in_valid(req_valid),
      .in_sample, .push, .filtered
   );

   amd_fifo u_fifo (
      .clock, .reset, .push, .push_data(filtered), .pop(q_pop),
      .pop_data(q_data), .status(q_status)
   );

   amd_back u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .q_status, .q_data,
      .q_pop, .rsp_valid, .rsp_stall, .rsp_active, .rsp_moving,
      .rsp_drive_quality, .rsp_energy_level
   );
endmodule

@@ sv/amd_front.sv @@
// front end: accepts samples, runs the per-axis median windows
// depends on amd_pkg
module amd_front #(
   parameter int MEDIAN_TAPS = 5
) (
   input  logic clock,
   input  logic reset,
   input  logic push_ok,
   input  logic in_valid,
   input  amd_pkg::sample_vec_type in_sample,
   output logic push,
   output amd_pkg::sample_vec_type filtered
);
   import amd_pkg::*;
   localparam int K = (MEDIAN_TAPS - 1) / 2;
   localparam int CW = $clog2(MEDIAN_TAPS + 1);

   sample_type win_ff [AXES][MEDIAN_TAPS];
   sample_type win_in [AXES][MEDIAN_TAPS];

   assign push = in_valid && push_ok;

   always_comb begin
      logic [CW-1:0] lt, le;
      logic found;
      sample_type med;
      for (int a = 0; a < AXES; a++) begin
         win_in[a][0] = in_sample[a];
         for (int i = 1; i < MEDIAN_TAPS; i++) win_in[a][i] = win_ff[a][i-1];
         found = 1'b0;
         med = '0;
         for (int i = 0; i < MEDIAN_TAPS; i++) begin
            lt = '0;
            le = '0;
            for (int j = 0; j < MEDIAN_TAPS; j++) begin
               lt = lt + CW'(win_in[a][j] < win_in[a][i]);
               le = le + CW'(win_in[a][j] <= win_in[a][i]);
            end
            if (!found && lt <= CW'(K) && le > CW'(K)) begin
               found = 1'b1;
               med = win_in[a][i];
            end
         end
         filtered[a] = (med != '0) ? med : in_sample[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++)
            for (int i = 0; i < MEDIAN_TAPS; i++) win_ff[a][i] <= '0;
      end else if (push) begin
         win_ff <= win_in;
      end
   end
endmodule

@@ sv/amd_fifo.sv @@
// two-entry queue between front and back end
// depends on amd_pkg
module amd_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  amd_pkg::sample_vec_type push_data,
   input  logic pop,
   output amd_pkg::sample_vec_type pop_data,
   output amd_pkg::fifo_status_type status
);
   import amd_pkg::*;
   sample_vec_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign status.full = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

@@ sv/amd_back.sv @@
// back end: averages, energy, activity and motion state, result register
// depends on amd_pkg
module amd_back (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data,
   input  amd_pkg::fifo_status_type q_status,
   input  amd_pkg::sample_vec_type q_data,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_active,
   output logic rsp_moving,
   output logic [3:0] rsp_drive_quality,
   output logic [3:0] rsp_energy_level
);
   import amd_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] act_thresh_ff, mot_thresh_ff;
   logic [4:0] act_hold_ff;
   logic [3:0] warmup_left_ff;
   logic preset_ff;

   sample_type smp_ff [AXES];
   logic signed [39:0] fast_ff [AXES];
   logic signed [39:0] slow_ff [AXES];
   logic signed [39:0] fb_ff [AXES];
   logic signed [39:0] sb_ff [AXES];
   logic neg_ff [AXES];
   logic [31:0] n_ff [AXES];
   logic [63:0] p_ff [AXES];
   logic [16:0] tm_ff [AXES];
   logic [33:0] sqr_ff [AXES];

   logic [4:0] hold_ff;
   logic active_ff, moving_ff;
   logic [12:0] score_ff;
   logic [3:0] quality_ff;
   logic rsp_valid_ff;

   logic signed [39:0] sq40 [AXES];
   logic signed [39:0] fb [AXES];
   logic signed [39:0] sb [AXES];
   logic signed [40:0] d1 [AXES];
   logic signed [40:0] mag1 [AXES];
   logic signed [39:0] fn [AXES];
   logic signed [40:0] d2 [AXES];
   logic signed [40:0] mag2 [AXES];
   logic signed [39:0] sn [AXES];
   logic signed [40:0] d3 [AXES];
   logic signed [40:0] mag3 [AXES];

   logic [35:0] energy;
   logic [5:0] hold_up;
   logic [4:0] hold_in;
   logic active_in, moving_in;
   logic [12:0] score_in;
   logic [3:0] level, quality_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (!q_status.empty) state_in = B_DIFF;
         B_DIFF: state_in = B_MUL1;
         B_MUL1: state_in = B_FAST;
         B_FAST: state_in = B_MUL2;
         B_MUL2: state_in = B_SLOW;
         B_SLOW: state_in = B_SQUARE;
         B_SQUARE: state_in = B_DONE;
         B_DONE: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == B_IDLE) && !q_status.empty;
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         sq40[a] = {{8{smp_ff[a][15]}}, smp_ff[a], 16'b0};
         fb[a] = preset_ff ? sq40[a] : fast_ff[a];
         sb[a] = preset_ff ? sq40[a] : slow_ff[a];
         d1[a] = {sq40[a][39], sq40[a]} - {fb[a][39], fb[a]};
         mag1[a] = d1[a][40] ? -d1[a] : d1[a];
         fn[a] = neg_ff[a] ? fb_ff[a] - 40'(p_ff[a][63:34]) : fb_ff[a] + 40'(p_ff[a][63:34]);
         d2[a] = {fn[a][39], fn[a]} - {sb_ff[a][39], sb_ff[a]};
         mag2[a] = d2[a][40] ? -d2[a] : d2[a];
         sn[a] = neg_ff[a] ? sb_ff[a] - 40'(p_ff[a][63:38]) : sb_ff[a] + 40'(p_ff[a][63:38]);
         d3[a] = {fast_ff[a][39], fast_ff[a]} - {sn[a][39], sn[a]};
         mag3[a] = d3[a][40] ? -d3[a] : d3[a];
      end
   end

   always_comb begin
      energy = 36'(sqr_ff[0]) + 36'(sqr_ff[1]) + 36'(sqr_ff[2]);
      hold_up = 6'(hold_ff) + 6'd1;
      if (energy > 36'(act_thresh_ff)) begin
         active_in = 1'b1;
         hold_in = (hold_up > 6'(act_hold_ff)) ? act_hold_ff : hold_up[4:0];
      end else if (hold_ff <= 5'd1) begin
         active_in = 1'b0;
         hold_in = 5'd1;
      end else begin
         active_in = active_ff;
         hold_in = hold_ff - 5'd1;
      end
      if (energy > 36'(mot_thresh_ff)) begin
         if (score_ff < SCORE_JUMP) score_in = SCORE_JUMP;
         else if (score_ff >= SCORE_MAX) score_in = SCORE_MAX;
         else score_in = score_ff + 13'd1;
      end else if (score_ff >= 13'd2) begin
         score_in = score_ff - 13'd2;
      end else begin
         score_in = '0;
      end
      moving_in = moving_ff;
      if (score_in >= SCORE_ON) moving_in = 1'b1;
      if (score_in <= SCORE_OFF) moving_in = 1'b0;
      level = '0;
      for (int k = 1; k <= LEVEL_MAX; k++)
         if (energy >= 36'(k) * LEVEL_STEP) level = 4'(k);
      quality_in = level;
      if (moving_in && quality_ff > level) quality_in = quality_ff;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            for (int a = 0; a < AXES; a++) smp_ff[a] <= q_data[a];
         end
         B_DIFF: begin
            for (int a = 0; a < AXES; a++) begin
               fb_ff[a] <= fb[a];
               sb_ff[a] <= sb[a];
               neg_ff[a] <= d1[a][40];
               n_ff[a] <= mag1[a][33:2];
            end
         end
         B_MUL1, B_MUL2: begin
            for (int a = 0; a < AXES; a++)
               p_ff[a] <= {32'b0, n_ff[a]} * {32'b0, (state_ff == B_MUL1) ? RECIP_5 : RECIP_125};
         end
         B_FAST: begin
            for (int a = 0; a < AXES; a++) begin
               fast_ff[a] <= fn[a];
               neg_ff[a] <= d2[a][40];
               n_ff[a] <= mag2[a][34:3];
            end
         end
         B_SLOW: begin
            for (int a = 0; a < AXES; a++) begin
               slow_ff[a] <= sn[a];
               tm_ff[a] <= mag3[a][32:16];
            end
         end
         B_SQUARE: begin
            for (int a = 0; a < AXES; a++) sqr_ff[a] <= 34'(tm_ff[a]) * 34'(tm_ff[a]);
         end
         default: begin
         end
      endcase
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            fast_ff[a] <= '0;
            slow_ff[a] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         act_thresh_ff <= 32'd30;
         mot_thresh_ff <= 32'd100000;
         act_hold_ff <= 5'd20;
         warmup_left_ff <= 4'd10;
         preset_ff <= 1'b0;
         hold_ff <= 5'd1;
         active_ff <= 1'b0;
         moving_ff <= 1'b0;
         score_ff <= '0;
         quality_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (q_pop) begin
            preset_ff <= warmup_left_ff != '0;
            if (warmup_left_ff != '0) warmup_left_ff <= warmup_left_ff - 4'd1;
         end
         if (state_ff == B_DONE && out_free) begin
            hold_ff <= hold_in;
            active_ff <= active_in;
            moving_ff <= moving_in;
            score_ff <= score_in;
            quality_ff <= quality_in;
            rsp_valid_ff <= 1'b1;
            rsp_energy_level <= level;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ACT_THRESH: act_thresh_ff <= csr_data;
               CSR_MOT_THRESH: mot_thresh_ff <= csr_data;
               CSR_ACT_HOLD: act_hold_ff <= csr_data[4:0];
               CSR_WARMUP: warmup_left_ff <= csr_data[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_active = active_ff;
   assign rsp_moving = moving_ff;
   assign rsp_drive_quality = quality_ff;
endmodule

@@ sv/amd_checker.sv @@
// port-level checks of the accelerometer median motion detector
// bound to accel_median_motion_detector_unit
module amd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_moving,
   input logic [3:0] rsp_drive_quality,
   input logic [3:0] rsp_energy_level
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_moving |-> rsp_drive_quality == rsp_energy_level)
      else $error("quality differs while still");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moving |-> rsp_drive_quality >= rsp_energy_level)
      else $error("quality below level while moving");
endmodule

bind accel_median_motion_detector_unit amd_checker u_amd_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_moving,
   .rsp_drive_quality, .rsp_energy_level
);

@@ tb/tb_accel_median_motion_detector_unit.sv @@
// testbench of the accelerometer median motion detector: random and directed samples,
// per-axis median and dual average prediction, random idling on both channels
// depends on amd_pkg and accel_median_motion_detector_unit
module tb_accel_median_motion_detector_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import amd_pkg::*;

   localparam int TAPS = 5;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct {
      logic active;
      logic moving;
      logic [3:0] drive_quality;
      logic [3:0] energy_level;
   } motion_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_sample_x;
   logic signed [15:0] req_sample_y;
   logic signed [15:0] req_sample_z;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_active;
   logic rsp_moving;
   logic [3:0] rsp_drive_quality;
   logic [3:0] rsp_energy_level;
   logic csr_write;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   accel_median_motion_detector_unit #(.MEDIAN_TAPS(TAPS)) dut (.*);

   // predictor state
   logic [31:0] act_thresh;
   logic [31:0] mot_thresh;
   logic [4:0] hold_cap;
   int window[AXES][TAPS];
   longint fast_avg[AXES];
   longint slow_avg[AXES];
   int warmup_left;
   int hold_count;
   logic active_flag;
   int motion_score;
   logic moving_flag;
   int quality_level;

   motion_result_type pending_results[$];
   int error_count;
   int items_sent;
   int results_seen;
   int moving_seen;
   int top_level_seen;
   int cycle_count;
   bit idle_on;
   int hold_left;
   int seg_left;
   int seg_amp[AXES];
   int seg_base[AXES];
   int seg_period;
   int seg_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
               want);
   endtask

   function automatic int median_of_window(input int axis);
      int sorted[TAPS];
      int v;
      int j;
      for (int i = 0; i < TAPS; i++) begin
         v = window[axis][i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[(TAPS-1)/2];
   endfunction

   function automatic motion_result_type predict_motion(input int sx, input int sy,
                                                        input int sz);
      motion_result_type r;
      longint unsigned energy;
      longint sq;
      longint t;
      int s;
      int m;
      int level;
      bit preset;
      int samples[AXES];
      samples[0] = sx;
      samples[1] = sy;
      samples[2] = sz;
      preset = warmup_left != 0;
      energy = 0;
      for (int a = 0; a < AXES; a++) begin
         for (int i = TAPS - 1; i > 0; i--) window[a][i] = window[a][i-1];
         window[a][0] = samples[a];
         m = median_of_window(a);
         s = (m != 0) ? m : samples[a];
         sq = longint'(s) * 65536;
         if (preset) begin
            fast_avg[a] = sq;
            slow_avg[a] = sq;
         end
         fast_avg[a] += (sq - fast_avg[a]) / 20;
         slow_avg[a] += (fast_avg[a] - slow_avg[a]) / 1000;
         t = (fast_avg[a] - slow_avg[a]) / 65536;
         energy += longint'(t * t);
      end
      if (preset) warmup_left--;

      if (energy > longint'(act_thresh)) begin
         active_flag = 1'b1;
         hold_count++;
         if (hold_count > hold_cap) hold_count = hold_cap;
      end else if (hold_count <= 1) begin
         active_flag = 1'b0;
         hold_count = 1;
      end else begin
         hold_count--;
      end

      if (energy > longint'(mot_thresh)) begin
         if (motion_score < int'(SCORE_JUMP)) motion_score = int'(SCORE_JUMP);
         else motion_score++;
      end else if (motion_score > 0) begin
         motion_score -= 2;
      end
      if (motion_score > int'(SCORE_MAX)) motion_score = int'(SCORE_MAX);
      if (motion_score >= int'(SCORE_ON)) moving_flag = 1'b1;
      if (motion_score < 0) motion_score = 0;
      if (motion_score <= int'(SCORE_OFF)) moving_flag = 1'b0;

      energy = energy / 4000000;
      level = (energy > LEVEL_MAX) ? LEVEL_MAX : int'(energy);
      if (level > quality_level) quality_level = level;
      if (!moving_flag) quality_level = level;

      r.active = active_flag;
      r.moving = moving_flag;
      r.drive_quality = quality_level[3:0];
      r.energy_level = level[3:0];
      return r;
   endfunction

   task automatic send_sample(input int sx, input int sy, input int sz);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_x = sx[15:0];
      req_sample_y = sy[15:0];
      req_sample_z = sz[15:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_motion(sx, sy, sz));
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (index)
         CSR_ACT_THRESH: act_thresh = value;
         CSR_MOT_THRESH: mot_thresh = value;
         CSR_ACT_HOLD: hold_cap = value[4:0];
         CSR_WARMUP: warmup_left = value[3:0];
         default: begin
         end
      endcase
   endtask

   // mostly square waves with random content, some full-range noise
   task automatic send_random(input int count);
      int v[AXES];
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 18) begin
            for (int a = 0; a < AXES; a++) v[a] = $signed(16'($urandom));
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(60, 5);
               seg_period = $urandom_range(40, 2);
               seg_phase = 0;
               for (int a = 0; a < AXES; a++) begin
                  seg_amp[a] = $urandom_range(16000, 0);
                  seg_base[a] = $urandom_range(32000, 0) - 16000;
               end
            end
            seg_left--;
            seg_phase++;
            for (int a = 0; a < AXES; a++) begin
               v[a] = seg_base[a] + (((seg_phase / seg_period) % 2) ? seg_amp[a]
                                                                   : -seg_amp[a]);
               v[a] += $urandom_range(64, 0) - 32;
               if (v[a] > 32767) v[a] = 32767;
               if (v[a] < -32768) v[a] = -32768;
            end
         end
         send_sample(v[0], v[1], v[2]);
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = idle_on && $urandom_range(99) < 14;
         end
      end
   end

   always @(posedge clock) begin
      motion_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_active !== want.active) report_mismatch("active", rsp_active, want.active);
            if (rsp_moving !== want.moving) report_mismatch("moving", rsp_moving, want.moving);
            if (rsp_drive_quality !== want.drive_quality)
               report_mismatch("drive_quality", rsp_drive_quality, want.drive_quality);
            if (rsp_energy_level !== want.energy_level)
               report_mismatch("energy_level", rsp_energy_level, want.energy_level);
            if (want.moving) moving_seen++;
            if (want.energy_level == 4'd15) top_level_seen++;
         end
         results_seen++;
      end
   end

   task automatic test_extremes();
      send_sample(0, 0, 0);
      send_sample(32767, -32768, 0);
      send_sample(-32768, 32767, 1);
      send_sample(-1, -1, -1);
      for (int i = 0; i < 8; i++) send_sample(32767, 32767, 32767);
      for (int i = 0; i < 8; i++) send_sample(-32768, -32768, -32768);
      send_sample(21845, -21846, 0);
      drain_results();
   endtask

   task automatic test_settings();
      write_csr(CSR_ACT_THRESH, 32'd0);
      write_csr(CSR_MOT_THRESH, 32'd0);
      write_csr(CSR_ACT_HOLD, 32'd0);
      write_csr(CSR_WARMUP, 32'd0);
      send_random(120);
      drain_results();
      write_csr(CSR_ACT_THRESH, 32'hFFFF_FFFF);
      write_csr(CSR_MOT_THRESH, 32'hFFFF_FFFF);
      write_csr(CSR_ACT_HOLD, 32'd31);
      write_csr(CSR_WARMUP, 32'd15);
      send_random(100);
      drain_results();
      write_csr(CSR_ACT_THRESH, 32'd5000);
      write_csr(CSR_MOT_THRESH, 32'd2000);
      write_csr(CSR_ACT_HOLD, 32'd1);
      write_csr(CSR_WARMUP, 32'd3);
      send_random(150);
      drain_results();
   endtask

   task automatic test_quiet_stretch();
      idle_on = 1'b0;
      write_csr(CSR_ACT_HOLD, 32'd7);
      send_random(120);
      drain_results();
      idle_on = 1'b1;
   endtask

   task automatic test_receiver_hold();
      @(negedge clock);
      hold_left = 300;
      send_random(40);
      drain_results();
   endtask

   task automatic test_random_configs();
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_ACT_THRESH, $urandom_range(200000, 0));
         write_csr(CSR_MOT_THRESH, $urandom_range(400000, 0));
         write_csr(CSR_ACT_HOLD, $urandom_range(31, 1));
         if ($urandom_range(1, 0)) write_csr(CSR_WARMUP, $urandom_range(15, 0));
         send_random(80);
         drain_results();
      end
   endtask

   initial begin
      cycle_count = 0;
      error_count = 0;
      items_sent = 0;
      results_seen = 0;
      moving_seen = 0;
      top_level_seen = 0;
      idle_on = 1'b1;
      hold_left = 0;
      seg_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      csr_write = 1'b0;
      csr_index = CSR_ACT_THRESH;
      csr_data = '0;
      act_thresh = 32'd30;
      mot_thresh = 32'd100000;
      hold_cap = 5'd20;
      warmup_left = 10;
      hold_count = 1;
      active_flag = 1'b0;
      motion_score = 0;
      moving_flag = 1'b0;
      quality_level = 0;
      for (int a = 0; a < AXES; a++) begin
         fast_avg[a] = 0;
         slow_avg[a] = 0;
         for (int i = 0; i < TAPS; i++) window[a][i] = 0;
      end
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_extremes();
      send_random(60);
      drain_results();
      test_settings();
      test_quiet_stretch();
      test_receiver_hold();
      test_random_configs();

      $display("%0d samples sent, %0d results checked, %0d while moving, %0d at top level",
               items_sent, results_seen, moving_seen, top_level_seen);
      $display("covered register extremes, warmup restarts, long output hold-off");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", error_count);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
